### hw/rtl/spjd_pkg.sv
package spjd_pkg;

    localparam int LEVELS_DEFAULT     = 8;
    localparam int FIFO_DEPTH_DEFAULT = 16;
    localparam int MAX_SLOTS_DEFAULT  = 16;

    localparam int JOB_W    = 16;
    localparam int PRIO_W   = 3;
    localparam int ACTION_W = 2;
    localparam int KIND_W   = 3;
    localparam int LIMIT_W  = 5;
    localparam int DATA_W   = 24;
    localparam int APB_W    = 32;
    localparam int PADDR_W  = 3;

    localparam logic [LIMIT_W-1:0] MAX_RUNNING_RESET = 5'd4;

    localparam logic REG_MAX_RUNNING = 1'b0;

    localparam logic [ACTION_W-1:0] ACT_ENQUEUE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_COMPLETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_UPDATE   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ENQUEUED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_COMPLETED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DISPATCHED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE       = 3'd4;

endpackage

### hw/rtl/strict_priority_job_dispatcher.sv
// Strict-priority job dispatcher.
// The input stream carries one command per transfer: enqueue a job at a
// priority level, report that a running job finished, or update. Each
// command gives one or more result transfers on the output stream, and
// m_tlast marks the final result of a command. An update dispatches jobs,
// highest non-empty level first, while the running count is below
// max_running (written over the APB port), capped at MAX_SLOTS; it returns
// one result per job, or a single "nothing dispatched" result. Unknown
// commands give no result. One command is processed at a time. An enqueue
// or a completion passes through the execute state into the result
// register. An update passes through the execute state to the scan state;
// every dispatch is one read of the job store memory there, its result is
// loaded from the read state, and the next pick waits for the updated
// counts; with nothing to dispatch, the scan state gives its single result.
// A result is held in the output register while m_tready is low, and work
// pauses until that register is free; s_tready stays low meanwhile.
// Reset empties every queue, clears the running count and sets max_running
// to 4. The job store itself is not cleared and needs no clearing pass, so
// the block accepts commands right after reset.
module strict_priority_job_dispatcher #(
    parameter int LEVELS     = spjd_pkg::LEVELS_DEFAULT,
    parameter int FIFO_DEPTH = spjd_pkg::FIFO_DEPTH_DEFAULT,
    parameter int MAX_SLOTS  = spjd_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // job_id [15:0], priority_req [18:16], zero [23:19]
    input  logic [spjd_pkg::DATA_W-1:0]      s_tdata,
    // action [1:0]
    input  logic [spjd_pkg::ACTION_W-1:0]    s_tuser,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_job [15:0], out_level [18:16], zero [23:19]
    output logic [spjd_pkg::DATA_W-1:0]      m_tdata,
    // kind [2:0]
    output logic [spjd_pkg::KIND_W-1:0]      m_tuser,
    output logic                             m_tlast,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [spjd_pkg::PADDR_W-1:0]     paddr,
    input  logic [spjd_pkg::APB_W-1:0]       pwdata,
    output logic [spjd_pkg::APB_W-1:0]       prdata,
    output logic                             pready
);

    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int RUN_W  = $clog2(MAX_SLOTS + 1);
    localparam int DEPTH  = LEVELS * FIFO_DEPTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_READ
    } state_t;

    state_t state_reg;

    logic [spjd_pkg::ACTION_W-1:0] action_reg;
    logic [spjd_pkg::JOB_W-1:0]    job_reg;
    logic [spjd_pkg::PRIO_W-1:0]   prio_reg;
    logic [LVL_W-1:0]              sel_level_reg;

    logic [PTR_W-1:0] head_reg  [LEVELS];
    logic [PTR_W-1:0] tail_reg  [LEVELS];
    logic [CNT_W-1:0] count_reg [LEVELS];
    logic [RUN_W-1:0] running_reg;
    logic [spjd_pkg::LIMIT_W-1:0] max_running_reg;

    logic [spjd_pkg::JOB_W-1:0] job_store [DEPTH];
    logic [spjd_pkg::JOB_W-1:0] rd_data_reg;

    logic                          m_valid_reg;
    logic [spjd_pkg::KIND_W-1:0]   m_kind_reg;
    logic [spjd_pkg::JOB_W-1:0]    m_job_reg;
    logic [spjd_pkg::PRIO_W-1:0]   m_level_reg;
    logic                          m_last_reg;

    logic [LVL_W-1:0]  enq_level;
    logic              enq_full;
    logic [LEVELS-1:0] nonempty;
    logic [LVL_W-1:0]  found;
    logic [CMP_W-1:0]  limit;
    logic              can_dispatch;
    logic              out_free;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;

    logic                          out_load;
    logic [spjd_pkg::KIND_W-1:0]   out_kind;
    logic [spjd_pkg::JOB_W-1:0]    out_job;
    logic [spjd_pkg::PRIO_W-1:0]   out_level;
    logic                          out_last;

    logic cfg_write;

    assign enq_level = (32'(prio_reg) > LEVELS - 1) ? LVL_W'(LEVELS - 1) : LVL_W'(prio_reg);
    assign enq_full  = (count_reg[enq_level] == CNT_W'(FIFO_DEPTH));

    always_comb begin
        found = '0;
        for (int i = 0; i < LEVELS; i++) begin
            nonempty[i] = (count_reg[i] != '0);
            if (nonempty[i]) begin
                found = LVL_W'(i);
            end
        end
    end

    assign limit = (32'(max_running_reg) > MAX_SLOTS) ? CMP_W'(MAX_SLOTS)
                                                      : CMP_W'(max_running_reg);
    assign can_dispatch = (CMP_W'(running_reg) < limit) && (|nonempty);
    assign out_free     = !m_valid_reg || m_tready;

    assign waddr = ADDR_W'(ADDR_W'(enq_level) * ADDR_W'(FIFO_DEPTH)) + ADDR_W'(tail_reg[enq_level]);
    assign raddr = ADDR_W'(ADDR_W'(found) * ADDR_W'(FIFO_DEPTH)) + ADDR_W'(head_reg[found]);

    assign mem_we = (state_reg == S_EXEC) && (action_reg == spjd_pkg::ACT_ENQUEUE)
                    && out_free && !enq_full;
    assign mem_re = (state_reg == S_SCAN) && can_dispatch;

    always_comb begin
        out_load  = 1'b0;
        out_kind  = spjd_pkg::KIND_NONE;
        out_job   = '0;
        out_level = '0;
        out_last  = 1'b1;
        case (state_reg)
            S_EXEC: begin
                if (out_free) begin
                    case (action_reg)
                        spjd_pkg::ACT_ENQUEUE: begin
                            out_load  = 1'b1;
                            out_kind  = enq_full ? spjd_pkg::KIND_REJECTED
                                                 : spjd_pkg::KIND_ENQUEUED;
                            out_job   = job_reg;
                            out_level = spjd_pkg::PRIO_W'(enq_level);
                        end
                        spjd_pkg::ACT_COMPLETE: begin
                            out_load = 1'b1;
                            out_kind = spjd_pkg::KIND_COMPLETED;
                        end
                        default: begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!can_dispatch && out_free) begin
                    out_load = 1'b1;
                    out_kind = spjd_pkg::KIND_NONE;
                end
            end
            S_READ: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    out_kind  = spjd_pkg::KIND_DISPATCHED;
                    out_job   = rd_data_reg;
                    out_level = spjd_pkg::PRIO_W'(sel_level_reg);
                    out_last  = !can_dispatch;
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            running_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (action_reg)
                        spjd_pkg::ACT_ENQUEUE: begin
                            if (out_free) begin
                                state_reg <= S_IDLE;
                            end
                            if (mem_we) begin
                                tail_reg[enq_level] <= (tail_reg[enq_level] == PTR_W'(FIFO_DEPTH - 1))
                                    ? '0 : tail_reg[enq_level] + PTR_W'(1);
                                count_reg[enq_level] <= count_reg[enq_level] + CNT_W'(1);
                            end
                        end
                        spjd_pkg::ACT_COMPLETE: begin
                            if (out_free) begin
                                state_reg <= S_IDLE;
                                if (running_reg != '0) begin
                                    running_reg <= running_reg - RUN_W'(1);
                                end
                            end
                        end
                        spjd_pkg::ACT_UPDATE: begin
                            state_reg <= S_SCAN;
                        end
                        default: begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_SCAN: begin
                    if (mem_re) begin
                        head_reg[found] <= (head_reg[found] == PTR_W'(FIFO_DEPTH - 1))
                            ? '0 : head_reg[found] + PTR_W'(1);
                        count_reg[found] <= count_reg[found] - CNT_W'(1);
                        running_reg      <= running_reg + RUN_W'(1);
                        state_reg        <= S_READ;
                    end else if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_READ: begin
                    if (out_free) begin
                        state_reg <= can_dispatch ? S_SCAN : S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            action_reg <= s_tuser;
            job_reg    <= s_tdata[spjd_pkg::JOB_W-1:0];
            prio_reg   <= s_tdata[spjd_pkg::JOB_W +: spjd_pkg::PRIO_W];
        end
        if (mem_re) begin
            sel_level_reg <= found;
        end
        if (out_load) begin
            m_kind_reg  <= out_kind;
            m_job_reg   <= out_job;
            m_level_reg <= out_level;
            m_last_reg  <= out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            job_store[waddr] <= job_reg;
        end
        if (mem_re) begin
            rd_data_reg <= job_store[raddr];
        end
    end

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == spjd_pkg::REG_MAX_RUNNING);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_running_reg <= spjd_pkg::MAX_RUNNING_RESET;
        end else if (cfg_write) begin
            max_running_reg <= pwdata[spjd_pkg::LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == spjd_pkg::REG_MAX_RUNNING)
                    ? spjd_pkg::APB_W'(max_running_reg) : '0;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(spjd_pkg::DATA_W - spjd_pkg::JOB_W - spjd_pkg::PRIO_W){1'b0}},
                       m_level_reg, m_job_reg};

endmodule

### dv/strict_priority_job_dispatcher_tb.sv
module strict_priority_job_dispatcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LEVELS   = spjd_pkg::LEVELS_DEFAULT;
    localparam int LEVEL_DEPTH  = spjd_pkg::FIFO_DEPTH_DEFAULT;
    localparam int DISPATCH_CAP = spjd_pkg::MAX_SLOTS_DEFAULT;

    localparam logic [spjd_pkg::ACTION_W-1:0] ACT_IGNORED = 2'd3;
    localparam logic [spjd_pkg::PADDR_W-1:0]  ADDR_MAX_RUNNING =
        spjd_pkg::PADDR_W'(4 * spjd_pkg::REG_MAX_RUNNING);

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 48;

    typedef struct packed {
        logic [spjd_pkg::KIND_W-1:0] kind;
        logic [spjd_pkg::JOB_W-1:0]  job;
        logic [spjd_pkg::PRIO_W-1:0] level;
        logic                        last;
    } job_result_t;

    logic                          aclk;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [spjd_pkg::DATA_W-1:0]   s_tdata = '0;
    logic [spjd_pkg::ACTION_W-1:0] s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [spjd_pkg::DATA_W-1:0]   m_tdata;
    logic [spjd_pkg::KIND_W-1:0]   m_tuser;
    logic                          m_tlast;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [spjd_pkg::PADDR_W-1:0]  paddr = '0;
    logic [spjd_pkg::APB_W-1:0]    pwdata = '0;
    logic [spjd_pkg::APB_W-1:0]    prdata;
    logic                          pready;

    int idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;
    int error_count = 0;
    int n_commands = 0;
    int n_results = 0;
    int n_dispatched = 0;
    int n_rejected = 0;
    int n_limit_writes = 0;

    // Model of the dispatcher: one queue of job identifiers per level.
    logic [spjd_pkg::JOB_W-1:0]   level_fifo [NUM_LEVELS][$];
    int unsigned                  model_running = 0;
    logic [spjd_pkg::LIMIT_W-1:0] model_limit = spjd_pkg::MAX_RUNNING_RESET;
    job_result_t                  expected_results [$];

    strict_priority_job_dispatcher u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending.",
                     cycle_count, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        job_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                $error("Unexpected result transfer: kind %0d, job %h, level %0d",
                       m_tuser, m_tdata[spjd_pkg::JOB_W-1:0],
                       m_tdata[spjd_pkg::JOB_W +: spjd_pkg::PRIO_W]);
                error_count++;
            end else begin
                exp_r = expected_results[0];
                expected_results.delete(0);
                if (m_tuser !== exp_r.kind) begin
                    $error("kind mismatch: expected %0d, actual %0d", exp_r.kind, m_tuser);
                    error_count++;
                end
                if (m_tdata[spjd_pkg::JOB_W-1:0] !== exp_r.job) begin
                    $error("out_job mismatch: expected %h, actual %h",
                           exp_r.job, m_tdata[spjd_pkg::JOB_W-1:0]);
                    error_count++;
                end
                if (m_tdata[spjd_pkg::JOB_W +: spjd_pkg::PRIO_W] !== exp_r.level) begin
                    $error("out_level mismatch: expected %0d, actual %0d",
                           exp_r.level, m_tdata[spjd_pkg::JOB_W +: spjd_pkg::PRIO_W]);
                    error_count++;
                end
                if (m_tlast !== exp_r.last) begin
                    $error("last mismatch: expected %0b, actual %0b", exp_r.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    function automatic void queue_expected(input logic [spjd_pkg::KIND_W-1:0] kind,
                                           input logic [spjd_pkg::JOB_W-1:0] job,
                                           input logic [spjd_pkg::PRIO_W-1:0] level,
                                           input logic last);
        job_result_t r;
        r.kind  = kind;
        r.job   = job;
        r.level = level;
        r.last  = last;
        expected_results = {expected_results, r};
    endfunction

    task automatic predict_command(input logic [spjd_pkg::ACTION_W-1:0] act,
                                   input logic [spjd_pkg::JOB_W-1:0] job,
                                   input logic [spjd_pkg::PRIO_W-1:0] prio);
        logic [spjd_pkg::JOB_W-1:0] popped;
        int unsigned cap;
        int          n;
        int          lv;
        case (act)
            spjd_pkg::ACT_ENQUEUE: begin
                if (level_fifo[prio].size() >= LEVEL_DEPTH) begin
                    queue_expected(spjd_pkg::KIND_REJECTED, job, prio, 1'b1);
                    n_rejected++;
                end else begin
                    level_fifo[prio] = {level_fifo[prio], job};
                    queue_expected(spjd_pkg::KIND_ENQUEUED, job, prio, 1'b1);
                end
            end
            spjd_pkg::ACT_COMPLETE: begin
                if (model_running > 0) begin
                    model_running--;
                end
                queue_expected(spjd_pkg::KIND_COMPLETED, '0, '0, 1'b1);
            end
            spjd_pkg::ACT_UPDATE: begin
                cap = (model_limit > DISPATCH_CAP) ? DISPATCH_CAP : model_limit;
                n = 0;
                while (model_running < cap && n < DISPATCH_CAP) begin
                    lv = -1;
                    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
                        if (lv < 0 && level_fifo[l].size() != 0) begin
                            lv = l;
                        end
                    end
                    if (lv < 0) begin
                        break;
                    end
                    popped = level_fifo[lv][0];
                    level_fifo[lv].delete(0);
                    queue_expected(spjd_pkg::KIND_DISPATCHED, popped,
                                   spjd_pkg::PRIO_W'(lv), 1'b0);
                    model_running++;
                    n_dispatched++;
                    n++;
                end
                if (n == 0) begin
                    queue_expected(spjd_pkg::KIND_NONE, '0, '0, 1'b1);
                end else begin
                    expected_results[expected_results.size() - 1].last = 1'b1;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_command(input logic [spjd_pkg::ACTION_W-1:0] act,
                                input logic [spjd_pkg::JOB_W-1:0] job,
                                input logic [spjd_pkg::PRIO_W-1:0] prio);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = spjd_pkg::DATA_W'({prio, job});
        do @(posedge aclk); while (!s_tready);
        predict_command(act, job, prio);
        n_commands++;
    endtask

    task automatic wait_until_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_running(input logic [spjd_pkg::APB_W-1:0] value);
        wait_until_drained();
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_MAX_RUNNING;
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        model_limit = value[spjd_pkg::LIMIT_W-1:0];
        n_limit_writes++;
        @(negedge aclk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[spjd_pkg::LIMIT_W-1:0] !== model_limit) begin
            $error("max_running mismatch: expected %0d, actual %0d",
                   model_limit, prdata[spjd_pkg::LIMIT_W-1:0]);
            error_count++;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic test_empty_and_ignored();
        idle_pct  = 0;
        stall_pct = 0;
        send_command(spjd_pkg::ACT_UPDATE, 16'h0000, 3'd0);
        send_command(spjd_pkg::ACT_COMPLETE, 16'hFFFF, 3'd7);
        send_command(ACT_IGNORED, 16'hFFFF, 3'd7);
        send_command(spjd_pkg::ACT_UPDATE, 16'hFFFF, 3'd7);
    endtask

    task automatic test_priority_order();
        send_command(spjd_pkg::ACT_ENQUEUE, 16'h0000, 3'd0);
        send_command(spjd_pkg::ACT_ENQUEUE, 16'hFFFF, 3'd7);
        send_command(spjd_pkg::ACT_ENQUEUE, 16'h1234, 3'd3);
        send_command(spjd_pkg::ACT_ENQUEUE, 16'h5555, 3'd3);
        send_command(spjd_pkg::ACT_ENQUEUE, 16'hAAAA, 3'd5);
        send_command(spjd_pkg::ACT_ENQUEUE, 16'h0001, 3'd0);
        send_command(spjd_pkg::ACT_UPDATE, 16'h0000, 3'd0);
        send_command(spjd_pkg::ACT_UPDATE, 16'h0000, 3'd0);
        send_command(spjd_pkg::ACT_COMPLETE, 16'h0000, 3'd0);
        send_command(spjd_pkg::ACT_UPDATE, 16'h0000, 3'd0);
    endtask

    task automatic test_limit_extremes();
        write_max_running(32'd0);
        send_command(spjd_pkg::ACT_UPDATE, 16'h0000, 3'd0);
        write_max_running(32'd31);
        send_command(spjd_pkg::ACT_ENQUEUE, 16'h8000, 3'd6);
        send_command(spjd_pkg::ACT_ENQUEUE, 16'h7FFF, 3'd1);
        send_command(spjd_pkg::ACT_UPDATE, 16'h0000, 3'd0);
        write_max_running(32'd1);
        send_command(spjd_pkg::ACT_UPDATE, 16'h0000, 3'd0);
        send_command(spjd_pkg::ACT_COMPLETE, 16'h0000, 3'd0);
        send_command(spjd_pkg::ACT_UPDATE, 16'h0000, 3'd0);
    endtask

    task automatic run_random_traffic(input int count, input int idle, input int stall,
                                      input int enq_w, input int comp_w, input int upd_w);
        int                            sent;
        int                            pick;
        logic [spjd_pkg::PRIO_W-1:0]   hot_level;
        logic [spjd_pkg::ACTION_W-1:0] act;
        logic [spjd_pkg::PRIO_W-1:0]   prio;
        sent      = 0;
        idle_pct  = idle;
        stall_pct = stall;
        hot_level = spjd_pkg::PRIO_W'($urandom_range(NUM_LEVELS - 1));
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < enq_w) begin
                act = spjd_pkg::ACT_ENQUEUE;
            end else if (pick < enq_w + comp_w) begin
                act = spjd_pkg::ACT_COMPLETE;
            end else if (pick < enq_w + comp_w + upd_w) begin
                act = spjd_pkg::ACT_UPDATE;
            end else begin
                act = ACT_IGNORED;
            end
            prio = $urandom_range(1) ? hot_level
                                     : spjd_pkg::PRIO_W'($urandom_range(NUM_LEVELS - 1));
            send_command(act, spjd_pkg::JOB_W'($urandom), prio);
            if (act != ACT_IGNORED) begin
                sent++;
            end
        end
    endtask

    task automatic test_random_no_idle();
        write_max_running(32'd16);
        run_random_traffic(98, 0, 0, 55, 25, 16);
    endtask

    task automatic test_random_sender_idle();
        write_max_running(32'd1);
        run_random_traffic(98, 71, 0, 40, 35, 21);
    endtask

    task automatic test_random_receiver_stall();
        write_max_running(32'd31);
        run_random_traffic(98, 0, 71, 45, 41, 10);
    endtask

    task automatic test_random_both_idle();
        write_max_running(spjd_pkg::APB_W'($urandom_range(15, 2)));
        run_random_traffic(98, 22, 22, 50, 26, 20);
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        test_empty_and_ignored();
        test_priority_order();
        test_limit_extremes();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        wait_until_drained();
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            error_count++;
        end
        $display("Sent %0d commands and checked %0d results: %0d jobs dispatched, %0d rejected.",
                 n_commands, n_results, n_dispatched, n_rejected);
        $display("Wrote max_running %0d times, with sender gaps and receiver stalls mixed in.",
                 n_limit_writes);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
